@@ design/lik_pkg.sv @@
package lik_pkg;

   // Field widths
   localparam int FOOT_W      = 16;
   localparam int LAT_W       = FOOT_W + 1;
   localparam int LEN_W       = 15;
   localparam int ANGLE_OUT_W = 16;
   localparam int KNEE_W      = 14;

   // Configuration register indexes and reset values
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_HIP_LINK   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_THIGH_LINK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SHIN_LINK  = 2'd2;
   localparam logic [LEN_W-1:0] HIP_LINK_RESET   = 15'd6095;
   localparam logic [LEN_W-1:0] THIGH_LINK_RESET = 15'd9634;
   localparam logic [LEN_W-1:0] SHIN_LINK_RESET  = 15'd15073;

   // Square root row: one result bit per cell
   localparam int SQRT_IN_W   = 64;
   localparam int SQRT_OUT_W  = SQRT_IN_W / 2;
   localparam int SQRT_REM_W  = SQRT_OUT_W + 2;
   localparam int SQRT_STAGES = SQRT_OUT_W;

   // CORDIC row: one micro-rotation per cell
   localparam int CORDIC_ITERATIONS = 16;
   localparam int ATAN_TABLE_LEN    = 24;
   localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS < ATAN_TABLE_LEN) ?
                                      CORDIC_ITERATIONS : ATAN_TABLE_LEN;
   localparam int SHIFT_W     = $clog2(ATAN_TABLE_LEN);
   localparam int GUARD_BITS  = 20;
   localparam int CIN_W       = 34;
   localparam int CORDIC_W    = CIN_W + GUARD_BITS + 2;
   localparam int ANG_W       = 32;
   localparam int ROUND_SHIFT = 14;

   localparam logic signed [ANG_W-1:0] ANG_90     = 32'sd94371840;
   localparam logic signed [ANG_W-1:0] ANG_180    = 32'sd188743680;
   localparam logic signed [ANG_W-1:0] ROUND_BIAS = 32'sd8192;

   // atan(2^-i) in units of 2^-20 degree
   localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_TABLE_LEN] = '{
      32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
      32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
      32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
      32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
      32'sd917,      32'sd458,      32'sd229,      32'sd115,
      32'sd57,       32'sd29,       32'sd14,       32'sd7
   };

   typedef struct packed {
      logic signed [FOOT_W-1:0] foot_x;
      logic signed [FOOT_W-1:0] foot_y;
      logic signed [FOOT_W-1:0] foot_z;
      logic                     right_side;
   } req_data_type;

   typedef struct packed {
      logic signed [ANGLE_OUT_W-1:0] abduction_angle;
      logic signed [ANGLE_OUT_W-1:0] hip_pitch_angle;
      logic        [KNEE_W-1:0]      knee_angle;
   } rsp_data_type;

   typedef struct packed {
      logic [SQRT_IN_W-1:0]  rad;
      logic [SQRT_REM_W-1:0] rem;
      logic [SQRT_OUT_W-1:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ANG_W-1:0]    z;
   } cordic_vec_type;

   typedef struct packed {
      logic                    spec;
      logic signed [ANG_W-1:0] base;
   } cordic_side_type;

endpackage

@@ design/lik_sqrt_cell.sv @@
module lik_sqrt_cell import lik_pkg::*; (
   input  logic           clock,
   input  logic           adv,
   input  sqrt_state_type st_prev,
   output sqrt_state_type st_out
);

   sqrt_state_type        st_ff;
   sqrt_state_type        st_in;
   logic [SQRT_REM_W-1:0] rem_t;
   logic [SQRT_REM_W-1:0] trial;

   // Bring down the next two radicand bits and try one root bit
   always_comb begin
      rem_t = {st_prev.rem[SQRT_REM_W-3:0], st_prev.rad[SQRT_IN_W-1 -: 2]};
      trial = {st_prev.root, 2'b01};
      st_in.rad = {st_prev.rad[SQRT_IN_W-3:0], 2'b00};
      if (rem_t >= trial) begin
         st_in.rem  = rem_t - trial;
         st_in.root = {st_prev.root[SQRT_OUT_W-2:0], 1'b1};
      end else begin
         st_in.rem  = rem_t;
         st_in.root = {st_prev.root[SQRT_OUT_W-2:0], 1'b0};
      end
   end

   // Advance
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_out = st_ff;

endmodule

@@ design/lik_sqrt_row.sv @@
module lik_sqrt_row import lik_pkg::*; (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [SQRT_IN_W-1:0]  radicand,
   output logic [SQRT_OUT_W-1:0] root
);

   sqrt_state_type st [0:SQRT_STAGES];

   // Start with empty remainder and root
   always_comb begin
      st[0].rad  = radicand;
      st[0].rem  = '0;
      st[0].root = '0;
   end

   // Chain the cells
   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_cell
      lik_sqrt_cell u_cell (
         .clock   (clock),
         .adv     (adv),
         .st_prev (st[i]),
         .st_out  (st[i+1])
      );
   end

   assign root = st[SQRT_STAGES].root;

endmodule

@@ design/lik_cordic_cell.sv @@
module lik_cordic_cell import lik_pkg::*; (
   input  logic                    clock,
   input  logic                    adv,
   input  logic [SHIFT_W-1:0]      shift,
   input  logic signed [ANG_W-1:0] angle,
   input  cordic_vec_type          vec_prev,
   output cordic_vec_type          vec_out
);

   cordic_vec_type             vec_ff;
   cordic_vec_type             vec_in;
   logic signed [CORDIC_W-1:0] sx;
   logic signed [CORDIC_W-1:0] sy;

   // Rotate toward the x axis by one step
   always_comb begin
      sx = vec_prev.x >>> shift;
      sy = vec_prev.y >>> shift;
      if (vec_prev.y > 0) begin
         vec_in.x = vec_prev.x + sy;
         vec_in.y = vec_prev.y - sx;
         vec_in.z = vec_prev.z + angle;
      end else begin
         vec_in.x = vec_prev.x - sy;
         vec_in.y = vec_prev.y + sx;
         vec_in.z = vec_prev.z - angle;
      end
   end

   // Advance
   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_out = vec_ff;

endmodule

@@ design/lik_cordic_row.sv @@
module lik_cordic_row import lik_pkg::*; (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [CIN_W-1:0] y_val,
   input  logic signed [CIN_W-1:0] x_val,
   output logic signed [ANG_W-1:0] angle
);

   cordic_vec_type          prep_vec_in;
   cordic_vec_type          prep_vec_ff;
   cordic_side_type         prep_side_in;
   cordic_side_type         prep_side_ff;
   cordic_side_type         side_ff [0:CORDIC_STAGES-1];
   cordic_vec_type          vec [0:CORDIC_STAGES];
   logic signed [CIN_W-1:0] xs;
   logic signed [CIN_W-1:0] ys;
   logic signed [ANG_W-1:0] angle_in;
   logic signed [ANG_W-1:0] angle_ff;

   // Resolve axis cases and fold the left half plane
   always_comb begin
      xs = x_val;
      ys = y_val;
      prep_side_in.spec = 1'b0;
      prep_side_in.base = '0;
      if (y_val == '0) begin
         prep_side_in.spec = 1'b1;
         prep_side_in.base = (x_val < 0) ? ANG_180 : '0;
      end else if (x_val == '0) begin
         prep_side_in.spec = 1'b1;
         prep_side_in.base = (y_val > 0) ? ANG_90 : -ANG_90;
      end else if (x_val < 0) begin
         prep_side_in.base = (y_val > 0) ? ANG_180 : -ANG_180;
         xs = -x_val;
         ys = -y_val;
      end
      prep_vec_in.x = $signed(CORDIC_W'(xs)) <<< GUARD_BITS;
      prep_vec_in.y = $signed(CORDIC_W'(ys)) <<< GUARD_BITS;
      prep_vec_in.z = '0;
   end

   // Register the prepared operands
   always_ff @(posedge clock) begin
      if (adv) begin
         prep_vec_ff  <= prep_vec_in;
         prep_side_ff <= prep_side_in;
      end
   end

   assign vec[0] = prep_vec_ff;

   // Chain the rotation cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      lik_cordic_cell u_cell (
         .clock    (clock),
         .adv      (adv),
         .shift    (SHIFT_W'(i)),
         .angle    (ATAN_TAB[i]),
         .vec_prev (vec[i]),
         .vec_out  (vec[i+1])
      );
   end

   // Carry the base angle alongside the cells
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= prep_side_ff;
         for (int k = 1; k < CORDIC_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Add the base angle, or take it alone on an axis
   assign angle_in = side_ff[CORDIC_STAGES-1].spec ? side_ff[CORDIC_STAGES-1].base :
                     vec[CORDIC_STAGES].z + side_ff[CORDIC_STAGES-1].base;

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

@@ design/leg_inverse_kinematics_unit.sv @@
// Pipeline from an accepted request to its result in the output queue:
// 11 front stages, 32 square root cells, 18 CORDIC stages and 2 combine stages.
// Throughput: one request per cycle while results are taken; the pipeline stops
// only when the two-entry output queue is full.
// Reset clears the pipeline valid bits, the queue and the link lengths to defaults.
module leg_inverse_kinematics_unit import lik_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_data_type           rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]       csr_data
);

   localparam int FRONT = 11;
   localparam int LAT   = FRONT + SQRT_STAGES + CORDIC_STAGES + 2 + 2;

   typedef struct packed {
      logic signed [FOOT_W-1:0] x;
      logic signed [LAT_W-1:0]  y;
      logic signed [FOOT_W-1:0] z;
      logic [30:0]              xsq;
      logic [30:0]              ysq;
      logic [30:0]              zsq;
      logic [29:0]              l1sq;
      logic [29:0]              l2sq;
      logic [29:0]              l3sq;
      logic [30:0]              dn;
      logic [31:0]              d2;
      logic [30:0]              sum23;
      logic [31:0]              r2;
      logic [31:0]              h2;
      logic signed [CIN_W-1:0]  nraw;
      logic signed [CIN_W-1:0]  n;
      logic [30:0]              nmag;
      logic [61:0]              nsq;
      logic [61:0]              dnsq;
      logic [63:0]              b2;
      logic [61:0]              s2;
      logic [63:0]              a2;
      logic [63:0]              ba;
   } work_type;

   typedef struct packed {
      logic signed [FOOT_W-1:0] x;
      logic signed [LAT_W-1:0]  y;
      logic signed [FOOT_W-1:0] z;
      logic signed [CIN_W-1:0]  n;
   } side_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] th1;
      logic signed [ANG_W-1:0] pitch;
      logic signed [ANG_W-1:0] knee;
   } sum_type;

   logic [LEN_W-1:0]        hip_len_ff;
   logic [LEN_W-1:0]        thigh_len_ff;
   logic [LEN_W-1:0]        shin_len_ff;
   logic                    adv;
   logic [LAT-1:0]          vld_ff;
   logic [LAT-1:0]          vld_in;
   work_type                wk_in [1:FRONT];
   work_type                wk_ff [1:FRONT];
   logic signed [CIN_W-1:0] dn_s;
   side_type                side_ff [0:SQRT_STAGES-1];
   logic [SQRT_OUT_W-1:0]   rq;
   logic [SQRT_OUT_W-1:0]   sq_s2;
   logic [SQRT_OUT_W-1:0]   sq_a2;
   logic [SQRT_OUT_W-1:0]   sq_ba;
   side_type                sd;
   logic signed [ANG_W-1:0] ang_zy;
   logic signed [ANG_W-1:0] ang_rl;
   logic signed [ANG_W-1:0] ang_phi;
   logic signed [ANG_W-1:0] ang_asn;
   logic signed [ANG_W-1:0] ang_ar;
   logic signed [ANG_W-1:0] ar_fix;
   sum_type                 sum_in;
   sum_type                 sum_ff;
   logic signed [ANG_W-1:0] rnd_th1;
   logic signed [ANG_W-1:0] rnd_pitch;
   logic signed [ANG_W-1:0] rnd_knee;
   rsp_data_type            out_in;
   rsp_data_type            out_ff;
   rsp_data_type            q_ff [0:1];
   rsp_data_type            q_in [0:1];
   logic [1:0]              cnt_ff;
   logic [1:0]              cnt_in;
   logic                    push;
   logic                    pop;

   // Hold link lengths
   always_ff @(posedge clock) begin
      if (reset) begin
         hip_len_ff   <= HIP_LINK_RESET;
         thigh_len_ff <= THIGH_LINK_RESET;
         shin_len_ff  <= SHIN_LINK_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_HIP_LINK:   hip_len_ff   <= csr_data;
            REG_THIGH_LINK: thigh_len_ff <= csr_data;
            REG_SHIN_LINK:  shin_len_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance whenever the output queue has room
   assign adv       = (cnt_ff != 2'd2);
   assign req_ready = adv;
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign dn_s = $signed(CIN_W'(wk_ff[6].dn));

   // Front stages: squares, distances, knee cosine terms and square root operands
   always_comb begin
      wk_in[1]   = '0;
      wk_in[1].x = req_data.foot_x;
      wk_in[1].z = req_data.foot_z;
      wk_in[1].y = req_data.right_side ? -LAT_W'(req_data.foot_y) : LAT_W'(req_data.foot_y);

      wk_in[2]      = wk_ff[1];
      wk_in[2].xsq  = 31'(wk_ff[1].x * wk_ff[1].x);
      wk_in[2].ysq  = 31'(wk_ff[1].y * wk_ff[1].y);
      wk_in[2].zsq  = 31'(wk_ff[1].z * wk_ff[1].z);
      wk_in[2].l1sq = 30'(hip_len_ff * hip_len_ff);
      wk_in[2].l2sq = 30'(thigh_len_ff * thigh_len_ff);
      wk_in[2].l3sq = 30'(shin_len_ff * shin_len_ff);
      wk_in[2].dn   = {30'(thigh_len_ff * shin_len_ff), 1'b0};

      wk_in[3]       = wk_ff[2];
      wk_in[3].d2    = 32'(wk_ff[2].ysq) + 32'(wk_ff[2].zsq);
      wk_in[3].sum23 = 31'(wk_ff[2].l2sq) + 31'(wk_ff[2].l3sq);

      wk_in[4]    = wk_ff[3];
      wk_in[4].r2 = (wk_ff[3].d2 > 32'(wk_ff[3].l1sq)) ? wk_ff[3].d2 - 32'(wk_ff[3].l1sq) : '0;

      wk_in[5]    = wk_ff[4];
      wk_in[5].h2 = 32'(wk_ff[4].xsq) + wk_ff[4].r2;

      wk_in[6]      = wk_ff[5];
      wk_in[6].nraw = $signed(CIN_W'(wk_ff[5].sum23)) - $signed(CIN_W'(wk_ff[5].h2));

      wk_in[7] = wk_ff[6];
      if (wk_ff[6].nraw > dn_s) begin
         wk_in[7].n = dn_s;
      end else if (wk_ff[6].nraw < -dn_s) begin
         wk_in[7].n = -dn_s;
      end else begin
         wk_in[7].n = wk_ff[6].nraw;
      end
      wk_in[7].nmag = 31'((wk_in[7].n < 0) ? -wk_in[7].n : wk_in[7].n);

      wk_in[8]      = wk_ff[7];
      wk_in[8].nsq  = 62'(wk_ff[7].nmag * wk_ff[7].nmag);
      wk_in[8].dnsq = 62'(wk_ff[7].dn * wk_ff[7].dn);
      wk_in[8].b2   = {62'(wk_ff[7].l2sq * wk_ff[7].h2), 2'b00};

      wk_in[9]    = wk_ff[8];
      wk_in[9].s2 = wk_ff[8].dnsq - wk_ff[8].nsq;

      wk_in[10]    = wk_ff[9];
      wk_in[10].a2 = (64'(wk_ff[9].s2) > wk_ff[9].b2) ? wk_ff[9].b2 : 64'(wk_ff[9].s2);

      wk_in[11]    = wk_ff[10];
      wk_in[11].ba = wk_ff[10].b2 - wk_ff[10].a2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= FRONT; k++) begin
            wk_ff[k] <= wk_in[k];
         end
      end
   end

   // Square root rows
   lik_sqrt_row u_sqrt_r (
      .clock    (clock),
      .adv      (adv),
      .radicand ({16'b0, wk_ff[FRONT].r2, 16'b0}),
      .root     (rq)
   );

   lik_sqrt_row u_sqrt_s2 (
      .clock    (clock),
      .adv      (adv),
      .radicand (64'(wk_ff[FRONT].s2)),
      .root     (sq_s2)
   );

   lik_sqrt_row u_sqrt_a2 (
      .clock    (clock),
      .adv      (adv),
      .radicand (wk_ff[FRONT].a2),
      .root     (sq_a2)
   );

   lik_sqrt_row u_sqrt_ba (
      .clock    (clock),
      .adv      (adv),
      .radicand (wk_ff[FRONT].ba),
      .root     (sq_ba)
   );

   // Carry position and knee cosine past the square roots
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{x: wk_ff[FRONT].x, y: wk_ff[FRONT].y,
                         z: wk_ff[FRONT].z, n: wk_ff[FRONT].n};
         for (int k = 1; k < SQRT_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign sd = side_ff[SQRT_STAGES-1];

   // Angle rows
   lik_cordic_row u_cordic_zy (
      .clock (clock),
      .adv   (adv),
      .y_val (CIN_W'(sd.z)),
      .x_val (CIN_W'(sd.y)),
      .angle (ang_zy)
   );

   lik_cordic_row u_cordic_rl (
      .clock (clock),
      .adv   (adv),
      .y_val ($signed(CIN_W'(rq))),
      .x_val ($signed({11'b0, hip_len_ff, 8'b0})),
      .angle (ang_rl)
   );

   lik_cordic_row u_cordic_phi (
      .clock (clock),
      .adv   (adv),
      .y_val ($signed(CIN_W'(sq_s2))),
      .x_val (sd.n),
      .angle (ang_phi)
   );

   lik_cordic_row u_cordic_asn (
      .clock (clock),
      .adv   (adv),
      .y_val ($signed(CIN_W'(sq_a2))),
      .x_val ($signed(CIN_W'(sq_ba))),
      .angle (ang_asn)
   );

   lik_cordic_row u_cordic_ar (
      .clock (clock),
      .adv   (adv),
      .y_val (-$signed(CIN_W'(rq))),
      .x_val ($signed({{(CIN_W-FOOT_W-8){sd.x[FOOT_W-1]}}, sd.x, 8'b0})),
      .angle (ang_ar)
   );

   // Combine joint angles; fold straight back to -180
   assign ar_fix       = (ang_ar == ANG_180) ? -ANG_180 : ang_ar;
   assign sum_in.th1   = ang_zy + ang_rl;
   assign sum_in.knee  = ANG_180 - ang_phi;
   assign sum_in.pitch = ar_fix - ang_asn + ANG_90;

   // Round to output units
   assign rnd_th1   = (sum_ff.th1 + ROUND_BIAS) >>> ROUND_SHIFT;
   assign rnd_pitch = (sum_ff.pitch + ROUND_BIAS) >>> ROUND_SHIFT;
   assign rnd_knee  = (sum_ff.knee + ROUND_BIAS) >>> ROUND_SHIFT;
   assign out_in.abduction_angle = rnd_th1[ANGLE_OUT_W-1:0];
   assign out_in.hip_pitch_angle = rnd_pitch[ANGLE_OUT_W-1:0];
   assign out_in.knee_angle      = rnd_knee[KNEE_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
         out_ff <= out_in;
      end
   end

   // Output queue: two entries
   assign push = vld_ff[LAT-1] && adv;
   assign pop  = (cnt_ff != 2'd0) && rsp_ready;

   always_comb begin
      cnt_in  = cnt_ff;
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      case ({push, pop})
         2'b10: begin
            q_in[cnt_ff[0]] = out_ff;
            cnt_in          = cnt_ff + 2'd1;
         end
         2'b01: begin
            q_in[0] = q_ff[1];
            cnt_in  = cnt_ff - 2'd1;
         end
         2'b11: begin
            q_in[0] = out_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req_ready)
      else $error("request taken while output queue full");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1 && rsp_ready && !push) |=> !rsp_valid)
      else $error("single queued request not drained");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (cnt_ff == 2'd0 && vld_ff == '0))
      else $error("pipeline not cleared by reset");

endmodule
